// ===== rtl/core/mips_hilo_multiply_divide_unit_macros.svh =====
// Assertion macros shared by the multiply/divide unit.
// No dependencies; files that assert take this header by include.
`ifndef MIPS_HILO_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define MIPS_HILO_MULTIPLY_DIVIDE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge outside of reset.
`define MHMDU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MHMDU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MHMDU_ASSERT(lbl, clk, rstn, prop, msg)
`define MHMDU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/mhmdu_pkg.sv =====
// Package of the multiply/divide unit: operation codes, controller states,
// command struct and helper functions. No dependencies.
`default_nettype none

package mhmdu_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [WORD_W-1:0] SIGN_BIT      = 32'h8000_0000;
  localparam logic [WORD_W-1:0] ALL_ONES      = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] RESET_PATTERN = 32'hdead_c0de;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_MULT  = 3'd0,
    OP_MULTU = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MTHI  = 3'd4,
    OP_MTLO  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIX,
    S_WB
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic fix;
    logic commit;
  } cmd_t;

  function automatic logic [WORD_W-1:0] neg32(input logic [WORD_W-1:0] v);
    neg32 = {WORD_W{1'b0}} - v;
  endfunction

  // Two's complement magnitude; the most negative value maps onto itself,
  // which is its correct unsigned magnitude.
  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
    mag32 = v[WORD_W-1] ? neg32(v) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mhmdu_if.sv =====
// Handshake channels of the multiply/divide unit: operation items in and
// HI/LO result items out. Depends on mhmdu_pkg.
`default_nettype none

interface mhmdu_in_if;
  logic                            valid;
  logic                            ready;
  logic [mhmdu_pkg::OP_W-1:0]      op;
  logic [mhmdu_pkg::WORD_W-1:0]    operand_a;
  logic [mhmdu_pkg::WORD_W-1:0]    operand_b;

  modport source(output valid, output op, output operand_a, output operand_b,
                 input ready);
  modport sink(input valid, input op, input operand_a, input operand_b,
               output ready);
endinterface

interface mhmdu_out_if;
  logic                            valid;
  logic                            ready;
  logic [mhmdu_pkg::WORD_W-1:0]    hi_out;
  logic [mhmdu_pkg::WORD_W-1:0]    lo_out;

  modport source(output valid, output hi_out, output lo_out, input ready);
  modport sink(input valid, input hi_out, input lo_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mhmdu_ctrl.sv =====
// Controller of the multiply/divide unit: runs multiply or divide iterations,
// sign fix-up and write-back; moves go to write-back only. Uses mhmdu_pkg.
`default_nettype none

`include "mips_hilo_multiply_divide_unit_macros.svh"

module mhmdu_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  input  wire [mhmdu_pkg::OP_W-1:0]   in_op,
  output logic                        in_ready,
  input  wire                         out_ready,
  output logic                        out_valid,
  output mhmdu_pkg::cmd_t             cmd
);

  mhmdu_pkg::state_t               state_r, state_nxt;
  logic [mhmdu_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            in_fire;

  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhmdu_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      mhmdu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (mhmdu_pkg::op_t'(in_op))
            mhmdu_pkg::OP_MULT, mhmdu_pkg::OP_MULTU: state_nxt = mhmdu_pkg::S_MUL;
            mhmdu_pkg::OP_DIV, mhmdu_pkg::OP_DIVU: begin
              state_nxt = mhmdu_pkg::S_DIV;
              cnt_nxt   = mhmdu_pkg::CNT_LAST;
            end
            default: state_nxt = mhmdu_pkg::S_WB;
          endcase
        end
      end
      mhmdu_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mhmdu_pkg::S_FIX;
      end
      mhmdu_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = mhmdu_pkg::S_FIX;
        end
      end
      mhmdu_pkg::S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = mhmdu_pkg::S_WB;
      end
      mhmdu_pkg::S_WB: begin
        // The result register must be free or draining before it is reloaded.
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = mhmdu_pkg::S_IDLE;
        end
      end
      default: state_nxt = mhmdu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  `MHMDU_ASSERT(a_div_start, clk, rst_n,
    in_fire && (in_op == mhmdu_pkg::OP_DIV || in_op == mhmdu_pkg::OP_DIVU)
    |=> state_r == mhmdu_pkg::S_DIV && cnt_r == mhmdu_pkg::CNT_LAST,
    "divide item did not start a full iteration run")
  `MHMDU_ASSERT(a_div_end, clk, rst_n,
    state_r == mhmdu_pkg::S_DIV && cnt_r == '0 |=> state_r == mhmdu_pkg::S_FIX,
    "last divide iteration not followed by sign fix-up")
  `MHMDU_ASSERT(a_mul_seq, clk, rst_n,
    in_fire && (in_op == mhmdu_pkg::OP_MULT || in_op == mhmdu_pkg::OP_MULTU)
    |=> state_r == mhmdu_pkg::S_MUL ##1 state_r == mhmdu_pkg::S_FIX,
    "multiply item skipped its product or fix-up cycle")
  `MHMDU_ASSERT(a_no_overwrite, clk, rst_n,
    cmd.commit |-> !out_valid_r || out_ready,
    "pending result item overwritten")

endmodule

`default_nettype wire

// ===== rtl/core/mhmdu_dpath.sv =====
// Datapath of the multiply/divide unit: HI/LO state, multiplier, restoring
// divider, sign fix-up and result register. Uses mhmdu_pkg.
`default_nettype none

module mhmdu_dpath (
  input  wire                          clk,
  input  wire                          rst_n,
  input  mhmdu_pkg::cmd_t              cmd,
  input  wire [mhmdu_pkg::OP_W-1:0]    in_op,
  input  wire [mhmdu_pkg::WORD_W-1:0]  in_operand_a,
  input  wire [mhmdu_pkg::WORD_W-1:0]  in_operand_b,
  output logic [mhmdu_pkg::WORD_W-1:0] out_hi,
  output logic [mhmdu_pkg::WORD_W-1:0] out_lo
);

  localparam int unsigned W = mhmdu_pkg::WORD_W;

  logic [W-1:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [W-1:0] res_hi_r, res_hi_nxt, res_lo_r, res_lo_nxt;
  logic [W-1:0] out_hi_r, out_hi_nxt, out_lo_r, out_lo_nxt;
  logic         neg_hi_r, neg_hi_nxt, neg_lo_r, neg_lo_nxt;
  logic         is_div_r, is_div_nxt;

  logic [W:0]     shifted, diff;
  logic [2*W-1:0] product, prod_neg;

  assign shifted  = {rem_r, quo_r[W-1]};
  assign diff     = shifted - {1'b0, dvs_r};
  assign product  = quo_r * dvs_r;
  assign prod_neg = {(2*W){1'b0}} - {rem_r, quo_r};

  assign out_hi = out_hi_r;
  assign out_lo = out_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= mhmdu_pkg::RESET_PATTERN;
      lo_r <= mhmdu_pkg::RESET_PATTERN;
    end else begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    dvs_r    <= dvs_nxt;
    res_hi_r <= res_hi_nxt;
    res_lo_r <= res_lo_nxt;
    out_hi_r <= out_hi_nxt;
    out_lo_r <= out_lo_nxt;
    neg_hi_r <= neg_hi_nxt;
    neg_lo_r <= neg_lo_nxt;
    is_div_r <= is_div_nxt;
  end

  always_comb begin
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvs_nxt    = dvs_r;
    res_hi_nxt = res_hi_r;
    res_lo_nxt = res_lo_r;
    out_hi_nxt = out_hi_r;
    out_lo_nxt = out_lo_r;
    neg_hi_nxt = neg_hi_r;
    neg_lo_nxt = neg_lo_r;
    is_div_nxt = is_div_r;

    if (cmd.load) begin
      // Signed work runs on magnitudes; the signs are applied in fix-up.
      // Division by zero needs no special path: the iterations then yield an
      // all-ones quotient and the dividend as remainder.
      unique case (mhmdu_pkg::op_t'(in_op))
        mhmdu_pkg::OP_MULT, mhmdu_pkg::OP_DIV: begin
          quo_nxt    = mhmdu_pkg::mag32(in_operand_a);
          dvs_nxt    = mhmdu_pkg::mag32(in_operand_b);
          rem_nxt    = '0;
          neg_lo_nxt = in_operand_a[W-1] ^ in_operand_b[W-1];
          neg_hi_nxt = in_operand_a[W-1];
          is_div_nxt = (mhmdu_pkg::op_t'(in_op) == mhmdu_pkg::OP_DIV);
        end
        mhmdu_pkg::OP_MULTU, mhmdu_pkg::OP_DIVU: begin
          quo_nxt    = in_operand_a;
          dvs_nxt    = in_operand_b;
          rem_nxt    = '0;
          neg_lo_nxt = 1'b0;
          neg_hi_nxt = 1'b0;
          is_div_nxt = (mhmdu_pkg::op_t'(in_op) == mhmdu_pkg::OP_DIVU);
        end
        mhmdu_pkg::OP_MTHI: begin
          res_hi_nxt = in_operand_a;
          res_lo_nxt = lo_r;
        end
        mhmdu_pkg::OP_MTLO: begin
          res_hi_nxt = hi_r;
          res_lo_nxt = in_operand_a;
        end
        default: begin
          res_hi_nxt = hi_r;
          res_lo_nxt = lo_r;
        end
      endcase
    end

    if (cmd.mul) begin
      {rem_nxt, quo_nxt} = product;
    end

    if (cmd.div_step) begin
      quo_nxt = {quo_r[W-2:0], ~diff[W]};
      rem_nxt = diff[W] ? shifted[W-1:0] : diff[W-1:0];
    end

    if (cmd.fix) begin
      if (is_div_r) begin
        res_hi_nxt = neg_hi_r ? mhmdu_pkg::neg32(rem_r) : rem_r;
        res_lo_nxt = neg_lo_r ? mhmdu_pkg::neg32(quo_r) : quo_r;
      end else begin
        {res_hi_nxt, res_lo_nxt} = neg_lo_r ? prod_neg : {rem_r, quo_r};
      end
    end

    if (cmd.commit) begin
      hi_nxt     = res_hi_r;
      lo_nxt     = res_lo_r;
      out_hi_nxt = res_hi_r;
      out_lo_nxt = res_lo_r;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mips_hilo_multiply_divide_unit.sv =====
// Multiply: product, sign fix-up, then write-back into the result register.
// Divide: 32 iterations of the one-bit-per-cycle restoring divider plus
// fix-up and write-back; moves only write back. Write-back waits for space.
// One item is in work at a time; a finished result waits in its own register.
// Reset (synchronous, active low) sets HI and LO to 0xdeadc0de, no result.
`default_nettype none

module mips_hilo_multiply_divide_unit (
  input  wire          clk,
  input  wire          rst_n,
  mhmdu_in_if.sink     in_ch,
  mhmdu_out_if.source  out_ch
);

  mhmdu_pkg::cmd_t cmd;

  mhmdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  mhmdu_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_ch.op),
    .in_operand_a (in_ch.operand_a),
    .in_operand_b (in_ch.operand_b),
    .out_hi       (out_ch.hi_out),
    .out_lo       (out_ch.lo_out)
  );

endmodule

`default_nettype wire
